[rtl/qsl_pkg.sv]
// ----------------------------------------------------------------------------
// qsl_pkg: shared constants, types and the quarter-wave sine table
// Widths of the oscillator datapath, queue sizing and the table builder
// that is evaluated at elaboration.
// ----------------------------------------------------------------------------
package qsl_pkg;

   localparam int TABLE_ADDR_BITS = 10;
   localparam int OUTPUT_BITS     = 16;
   localparam int FREQ_BITS       = 24;
   localparam int PPH_BITS        = 24;
   localparam int PHASE_BITS      = 32;
   localparam int PROD_BITS       = FREQ_BITS + PPH_BITS + 1;

   localparam int ROM_SIZE        = 1 << TABLE_ADDR_BITS;
   localparam int MAG_BITS        = OUTPUT_BITS - 1;
   localparam int AMP             = (1 << (OUTPUT_BITS - 1)) - 1;

   localparam logic [PPH_BITS-1:0] PPH_RESET   = PPH_BITS'(89478);
   localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS      = QUEUE_PTR_BITS + 1;

   typedef logic [MAG_BITS-1:0] mag_type;
   typedef mag_type rom_type [ROM_SIZE];

   // Top phase bits that the lookup needs: quadrant and table index
   typedef struct packed {
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] index;
   } phase_top_type;

   // Two Q30 multiplies of the running Taylor term by x
   function automatic logic [63:0] sq_step(logic [63:0] term, logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> 30;
      t = (t * x) >> 30;
      return t;
   endfunction

   // Q30 sine of x in [0, pi/2] by an alternating Taylor series
   function automatic logic [63:0] sin_q30(logic [63:0] x);
      logic [63:0] s;
      logic [63:0] t;
      s = x;
      t = x;
      t = sq_step(t, x) / 64'd6;   s = s - t;
      t = sq_step(t, x) / 64'd20;  s = s + t;
      t = sq_step(t, x) / 64'd42;  s = s - t;
      t = sq_step(t, x) / 64'd72;  s = s + t;
      t = sq_step(t, x) / 64'd110; s = s - t;
      t = sq_step(t, x) / 64'd156; s = s + t;
      t = sq_step(t, x) / 64'd210; s = s - t;
      t = sq_step(t, x) / 64'd272; s = s + t;
      t = sq_step(t, x) / 64'd342; s = s - t;
      t = sq_step(t, x) / 64'd420; s = s + t;
      t = sq_step(t, x) / 64'd506; s = s - t;
      t = sq_step(t, x) / 64'd600; s = s + t;
      return s;
   endfunction

   // Build the quarter-wave table, rounded to the output amplitude
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] r;
      for (int k = 0; k < ROM_SIZE; k++) begin
         x = (HALF_PI_Q30 * 64'(k) + 64'(ROM_SIZE / 2)) >> TABLE_ADDR_BITS;
         s = sin_q30(x);
         r = (s * 64'(AMP) + (64'd1 << 29)) >> 30;
         rom[k] = r[MAG_BITS-1:0];
      end
      return rom;
   endfunction

endpackage

[rtl/qsl_phase_fifo.sv]
// ----------------------------------------------------------------------------
// qsl_phase_fifo: short queue of phase words between front and back
// Register-based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module qsl_phase_fifo import qsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  phase_top_type push_data,
   output logic          full,
   input  logic          pop,
   output phase_top_type pop_data,
   output logic          empty
);

   phase_top_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Store a pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + COUNT_BITS'(do_push) - COUNT_BITS'(do_pop);
      end
   end

endmodule

[rtl/qsl_front.sv]
// ----------------------------------------------------------------------------
// qsl_front: sample intake and phase accumulator
// Registers frequency times phase_per_hz, then folds the step into the
// accumulator as the word enters the phase queue.
// ----------------------------------------------------------------------------
module qsl_front import qsl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [FREQ_BITS-1:0] req_frequency,
   input  logic                        req_sync,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [PPH_BITS-1:0]         csr_phase_per_hz,
   input  logic                        queue_full,
   output logic                        queue_push,
   output phase_top_type               queue_data
);

   logic [PPH_BITS-1:0]          pph_ff;
   logic                         s1_valid_ff;
   logic                         s1_sync_ff;
   logic [PHASE_BITS-1:0]        s1_inc_ff;
   logic [PHASE_BITS-1:0]        acc_ff;
   logic [PHASE_BITS-1:0]        acc_in;
   logic signed [PROD_BITS-1:0]  prod;
   logic                         accept;
   logic                         move;

   assign csr_ready = 1'b1;
   assign req_full  = s1_valid_ff && queue_full;
   assign accept    = req_push && !req_full;
   assign move      = s1_valid_ff && !queue_full;

   // Signed frequency times unsigned factor; step is product over 16
   assign prod = PROD_BITS'(req_frequency) * $signed({1'b0, pph_ff});

   // Next phase: clear on sync, else add the step modulo one cycle
   assign acc_in = s1_sync_ff ? '0 : acc_ff + s1_inc_ff;

   assign queue_push = move;
   assign queue_data = phase_top_type'(acc_in[PHASE_BITS-1 -: TABLE_ADDR_BITS + 2]);

   // Hold the configured phase step per hertz
   always_ff @(posedge clock) begin
      if (reset) begin
         pph_ff <= PPH_RESET;
      end else if (csr_valid && csr_ready) begin
         pph_ff <= csr_phase_per_hz;
      end
   end

   // Capture the product stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_inc_ff  <= prod[PHASE_BITS+3:4];
         s1_sync_ff <= req_sync;
      end
   end

   // Track product stage occupancy and update the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (move) begin
            s1_valid_ff <= 1'b0;
         end
         if (move) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Sync leaves the accumulator at zero
   a_sync_clears: assert property (@(posedge clock) disable iff (reset)
      (move && s1_sync_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared by sync");

   // A stalled product stage keeps its step
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && queue_full) |=> (s1_valid_ff && $stable(s1_inc_ff)))
      else $error("product stage lost while stalled");

endmodule

[rtl/qsl_back.sv]
// ----------------------------------------------------------------------------
// qsl_back: table lookup and result queue
// Reads the quarter-wave table at index and its mirror, folds by quadrant
// and queues the sine words until they are popped.
// ----------------------------------------------------------------------------
module qsl_back import qsl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  phase_top_type                 queue_data,
   output logic                          queue_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_0deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_90deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_180deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_270deg
);

   localparam rom_type SINE_ROM = build_rom();

   logic                           rd_valid_ff;
   logic [1:0]                     rd_quad_ff;
   logic                           rd_kzero_ff;
   mag_type                        mag_a_ff;
   mag_type                        mag_b_ff;
   logic [TABLE_ADDR_BITS-1:0]     addr_b;
   mag_type                        mag_b_fix;
   mag_type                        mag_0;
   mag_type                        mag_90;
   logic                           neg_0;
   logic                           neg_90;
   logic signed [OUTPUT_BITS-1:0]  val_0;
   logic signed [OUTPUT_BITS-1:0]  val_90;

   logic signed [OUTPUT_BITS-1:0]  q0_ff  [QUEUE_DEPTH];
   logic signed [OUTPUT_BITS-1:0]  q90_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]      wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]      rd_ptr_ff;
   logic [COUNT_BITS-1:0]          count_ff;
   logic [COUNT_BITS-1:0]          reserved;
   logic                           out_push;
   logic                           out_pop;

   // Issue a lookup only when the result queue has room for it
   assign reserved  = count_ff + COUNT_BITS'(rd_valid_ff);
   assign queue_pop = !queue_empty && (reserved < COUNT_BITS'(QUEUE_DEPTH));
   assign addr_b    = TABLE_ADDR_BITS'(0) - queue_data.index;

   // Read the table at index and at its mirror
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         mag_a_ff    <= SINE_ROM[queue_data.index];
         mag_b_ff    <= SINE_ROM[addr_b];
         rd_quad_ff  <= queue_data.quad;
         rd_kzero_ff <= (queue_data.index == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= queue_pop;
      end
   end

   // Fold by quadrant; the quarter-cycle output sits in the next quadrant
   assign mag_b_fix = rd_kzero_ff ? MAG_BITS'(AMP) : mag_b_ff;
   assign mag_0     = rd_quad_ff[0] ? mag_b_fix : mag_a_ff;
   assign mag_90    = rd_quad_ff[0] ? mag_a_ff : mag_b_fix;
   assign neg_0     = rd_quad_ff[1];
   assign neg_90    = rd_quad_ff[1] ^ rd_quad_ff[0];
   assign val_0     = neg_0  ? -$signed({1'b0, mag_0})  : $signed({1'b0, mag_0});
   assign val_90    = neg_90 ? -$signed({1'b0, mag_90}) : $signed({1'b0, mag_90});

   assign out_push  = rd_valid_ff;
   assign rsp_empty = (count_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;

   // Half-cycle outputs are the negated words
   assign rsp_out_0deg   = q0_ff[rd_ptr_ff];
   assign rsp_out_90deg  = q90_ff[rd_ptr_ff];
   assign rsp_out_180deg = -q0_ff[rd_ptr_ff];
   assign rsp_out_270deg = -q90_ff[rd_ptr_ff];

   // Store finished words
   always_ff @(posedge clock) begin
      if (out_push) begin
         q0_ff[wr_ptr_ff]  <= val_0;
         q90_ff[wr_ptr_ff] <= val_90;
      end
   end

   // Advance result queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (out_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + COUNT_BITS'(out_push) - COUNT_BITS'(out_pop);
      end
   end

   // A lookup in flight always has a free slot waiting
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (count_ff < COUNT_BITS'(QUEUE_DEPTH)))
      else $error("result queue overflow");

   // Fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("result count out of range");

endmodule

[rtl/quadrature_sine_lfo.sv]
// ----------------------------------------------------------------------------
// quadrature_sine_lfo: quadrature numerically controlled oscillator
// Phase accumulator with four sine outputs a quarter cycle apart.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  req      req_push/req_full  req_frequency, req_sync
//  rsp      rsp_empty/rsp_pop  rsp_out_0deg .. rsp_out_270deg
//  csr      csr_valid/ready    csr_phase_per_hz
//
// One sample per clock sustained while the result side keeps popping. The
// product register loads at the accepting edge; the sample then passes the
// accumulator and phase queue, the table read and the result queue, in that
// order. Synchronous reset clears the phase and both queues and restores
// phase_per_hz. A stalled result side fills the result queue, then the phase
// queue and the product register, and then raises req_full.
// ----------------------------------------------------------------------------
module quadrature_sine_lfo import qsl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [FREQ_BITS-1:0]   req_frequency,
   input  logic                          req_sync,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_0deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_90deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_180deg,
   output logic signed [OUTPUT_BITS-1:0] rsp_out_270deg,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [PPH_BITS-1:0]           csr_phase_per_hz
);

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   phase_top_type q_wdata;
   phase_top_type q_rdata;

   qsl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frequency    (req_frequency),
      .req_sync         (req_sync),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_phase_per_hz (csr_phase_per_hz),
      .queue_full       (q_full),
      .queue_push       (q_push),
      .queue_data       (q_wdata)
   );

   qsl_phase_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   qsl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (q_empty),
      .queue_data     (q_rdata),
      .queue_pop      (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_0deg   (rsp_out_0deg),
      .rsp_out_90deg  (rsp_out_90deg),
      .rsp_out_180deg (rsp_out_180deg),
      .rsp_out_270deg (rsp_out_270deg)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for quadrature_sine_lfo
// Drives sample words into the oscillator and checks every result word
// against an in-bench oscillator model that keeps its own phase, phase step
// and quarter-wave table. Directed samples cover reset state, step extremes
// and quadrant boundaries. Random traffic then runs under several
// sender and receiver idle patterns and phase-step settings.
// ----------------------------------------------------------------------------
module tb import qsl_pkg::*; ();

   localparam int CLOCK_PERIOD = 12;
   localparam int RANDOM_ITEMS = 150;
   localparam int REPORT_LIMIT = 40;
   localparam int SETTLE_CYCLES = 8;

   // One result word: index 0 is the 0 degree output, index 3 the 270 degree one
   typedef logic [3:0][OUTPUT_BITS-1:0] sine_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic signed [FREQ_BITS-1:0]   req_frequency;
   logic                          req_sync;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic signed [OUTPUT_BITS-1:0] rsp_out_0deg;
   logic signed [OUTPUT_BITS-1:0] rsp_out_90deg;
   logic signed [OUTPUT_BITS-1:0] rsp_out_180deg;
   logic signed [OUTPUT_BITS-1:0] rsp_out_270deg;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [PPH_BITS-1:0]           csr_phase_per_hz;

   // Oscillator model state
   mag_type               quarter_wave [ROM_SIZE];
   logic [PHASE_BITS-1:0] model_phase;
   logic [PPH_BITS-1:0]   model_phase_per_hz;
   sine_word_type         expected_sines [$];

   int mismatch_count;
   int send_idle_pct;
   int rsp_stall_pct;

   quadrature_sine_lfo uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frequency    (req_frequency),
      .req_sync         (req_sync),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_0deg     (rsp_out_0deg),
      .rsp_out_90deg    (rsp_out_90deg),
      .rsp_out_180deg   (rsp_out_180deg),
      .rsp_out_270deg   (rsp_out_270deg),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_phase_per_hz (csr_phase_per_hz)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Q30 sine of x in [0, pi/2]: alternating Taylor series, thirteen terms
   function automatic logic [63:0] taylor_sine_q30(input logic [63:0] x);
      logic [63:0] acc;
      logic [63:0] term;
      acc  = x;
      term = x;
      for (int n = 1; n <= 12; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / (64'(2 * n) * 64'(2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   // Mirror the quarter table by quadrant and negate the lower half cycle
   function automatic logic [OUTPUT_BITS-1:0] sine_of_phase(input logic [PHASE_BITS-1:0] ph);
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] k;
      logic [OUTPUT_BITS-1:0]     mag;
      quad = ph[PHASE_BITS-1 -: 2];
      k    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      if (quad[0]) begin
         mag = (k == 0) ? OUTPUT_BITS'(AMP)
                        : OUTPUT_BITS'(quarter_wave[TABLE_ADDR_BITS'(0) - k]);
      end else begin
         mag = OUTPUT_BITS'(quarter_wave[k]);
      end
      return quad[1] ? OUTPUT_BITS'(-mag) : mag;
   endfunction

   // Advance the model phase by one sample and return the four sines
   function automatic sine_word_type advance_oscillator(input logic signed [FREQ_BITS-1:0] freq,
                                                        input logic sync);
      longint        product;
      sine_word_type w;
      if (sync) begin
         model_phase = '0;
      end else begin
         // floor(freq * step / 16), kept modulo one cycle
         product     = longint'(freq) * longint'({1'b0, model_phase_per_hz});
         model_phase = model_phase + product[35:4];
      end
      for (int q = 0; q < 4; q++) begin
         w[q] = sine_of_phase(model_phase + (PHASE_BITS'(q) << 30));
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t ns  mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Send one sample word; enter and leave at a falling edge. With no idle
   // the push stays high, so the caller must send the next word in the same step.
   task automatic send_sample(input logic signed [FREQ_BITS-1:0] freq, input logic sync);
      req_push      <= 1'b1;
      req_frequency <= freq;
      req_sync      <= sync;
      do @(posedge clock); while (req_full);
      expected_sines.push_back(advance_oscillator(freq, sync));
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Write the phase step once the oscillator has drained
   task automatic set_phase_per_hz(input logic [PPH_BITS-1:0] value);
      req_push <= 1'b0;
      while (expected_sines.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_phase_per_hz <= value;
      do @(posedge clock); while (!csr_ready);
      model_phase_per_hz = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reset phase step: sync, then a few steps from zero phase
   task automatic test_reset_defaults();
      send_sample(24'sd0, 1'b1);
      send_sample(24'sd16, 1'b0);
      send_sample(24'sd8388607, 1'b0);
      send_sample(-24'sd8388608, 1'b0);
   endtask

   // Largest, zero and smallest phase steps, including floor of negatives
   task automatic test_step_extremes();
      set_phase_per_hz('1);
      send_sample(24'sd8388607, 1'b0);
      send_sample(-24'sd8388608, 1'b0);
      send_sample(24'sd0, 1'b0);
      send_sample(24'sd1, 1'b0);
      send_sample(-24'sd1, 1'b0);
      send_sample(24'sd8388607, 1'b1);
      set_phase_per_hz('0);
      send_sample(24'sd8388607, 1'b0);
      send_sample(-24'sd8388608, 1'b0);
      set_phase_per_hz(PPH_BITS'(1));
      send_sample(-24'sd1, 1'b0);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sd16, 1'b0);
   endtask

   // Step 8192 per Hz: 2^21 is a quarter cycle, -2^23 exactly one cycle back
   task automatic test_quadrant_walk();
      set_phase_per_hz(PPH_BITS'(8192));
      send_sample(24'sd0, 1'b1);
      repeat (4) send_sample(24'sd2097152, 1'b0);
      send_sample(-24'sd8388608, 1'b0);
      send_sample(-24'sd2097152, 1'b0);
      send_sample(24'sd2048, 1'b0);
      send_sample(24'sd1, 1'b0);
   endtask

   // Random frequencies of every magnitude, with an occasional sync
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [PPH_BITS-1:0] step);
      logic [31:0]                 raw;
      logic signed [FREQ_BITS-1:0] freq;
      set_phase_per_hz(step);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         raw  = $urandom;
         freq = $signed(raw[FREQ_BITS-1:0]) >>> $urandom_range(0, FREQ_BITS - 1);
         send_sample(freq, $urandom_range(15) == 0);
      end
   endtask

   // Pop result words, stalling at random
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check each popped word against the oldest expected one
   always @(posedge clock) begin
      sine_word_type got;
      sine_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_out_270deg, rsp_out_180deg, rsp_out_90deg, rsp_out_0deg};
         if (expected_sines.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_sines.pop_front();
            for (int q = 0; q < 4; q++) begin
               if (got[q] !== want[q]) begin
                  report_mismatch($sformatf("%0d deg: got %0d, expected %0d",
                                            q * 90, $signed(got[q]), $signed(want[q])));
               end
            end
         end
      end
   end

   initial begin
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] r;
      reset              = 1'b1;
      req_push           = 1'b0;
      req_frequency      = '0;
      req_sync           = 1'b0;
      rsp_pop            = 1'b0;
      csr_valid          = 1'b0;
      csr_phase_per_hz   = '0;
      mismatch_count     = 0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      model_phase        = '0;
      model_phase_per_hz = PPH_RESET;

      // Build the quarter-wave table, rounded to full scale
      for (int k = 0; k < ROM_SIZE; k++) begin
         x = (HALF_PI_Q30 * 64'(k) + 64'(ROM_SIZE / 2)) / 64'(ROM_SIZE);
         s = taylor_sine_q30(x);
         r = (s * 64'(AMP) + (64'd1 << 29)) >> 30;
         quarter_wave[k] = r[MAG_BITS-1:0];
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_step_extremes();
      test_quadrant_walk();
      test_random_traffic(0, 0, PPH_BITS'($urandom));
      test_random_traffic(88, 0, '1);
      test_random_traffic(0, 88, PPH_BITS'($urandom_range(1, 200000)));
      test_random_traffic(16, 16, PPH_BITS'($urandom));

      // Drain, then give stray words time to show up
      req_push <= 1'b0;
      while (expected_sines.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
